/* src/blm_pkg.sv */
package blm_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W   = 10;
  localparam int MV_W       = 16;
  localparam int DIVIDER_W  = 8;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Running average in millivolts with four fraction bits.
  localparam int AVG_W  = 20;
  localparam int FRAC_W = 4;

  // Full-scale ADC voltage in millivolts.
  localparam int              FULL_SCALE_W  = 12;
  localparam logic [11:0]     FULL_SCALE_MV = 12'd3000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_MV      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_Q4  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDED_LOWS = 2'd2;

  // Configuration reset values.
  localparam logic [MV_W-1:0]      CUT_MV_RESET      = 16'd3300;
  localparam logic [DIVIDER_W-1:0] DIVIDER_Q4_RESET  = 8'd32;
  localparam logic [COUNT_W-1:0]   NEEDED_LOWS_RESET = 4'd8;
  localparam logic [COUNT_W-1:0]   LOW_RUN_MAX       = 4'd15;

  typedef struct packed {
    logic                usb_present;
    logic [SAMPLE_W-1:0] adc_sample;
  } blm_in_t;

  typedef struct packed {
    logic [MV_W-1:0]    battery_mv;
    logic               is_low;
    logic [COUNT_W-1:0] low_count;
    logic               sleep_request;
  } blm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MUL1,
    ST_MUL2,
    ST_FOLD,
    ST_AVG,
    ST_EMIT
  } blm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_usb;
    logic add_sample;
    logic mean_load;
    logic fold_load;
    logic fold_step;
    logic mul_first;
    logic avg_update;
    logic emit;
  } blm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_sample;
    logic fold_done;
    logic out_free;
  } blm_stat_t;

endpackage

/* src/battery_low_monitor.sv */
// Low-battery monitor. Each transfer on the input carries one raw ADC sample
// of the battery divider (full scale 3.0 V) or, with usb_present set, notice
// of external power, which clears the low-reading run and the partial group
// and gives no result. Samples are summed in groups of SAMPLES_PER_READING;
// each complete group is reduced to its floored mean, scaled to millivolts
// with four fraction bits by the divider ratio in divider_q4, and folded into
// a running average with weight one half (any reading seeds it while the
// average is below 1 mV). One result leaves per complete group: the average
// rounded to whole millivolts (saturating at 65535), whether it is below
// cut_mv, the count of consecutive low readings (saturating at 15) and a
// sleep request once that count reaches needed_lows. The sample that
// completes a group occupies the block while it forms the mean (a shift, or
// a multiplication by the reciprocal when the group size is not a power of
// two), multiplies by the divider ratio and then by the full scale, runs the
// fold until it finishes, updates the average and loads the output register.
// The division by the ADC full-scale code, one less than a power of two,
// folds the high part of the remainder onto the low part step by step; for
// ten-bit samples this needs at most four steps. A finished result waits in
// an output register, so the input keeps taking samples while the result
// transfer is stalled; only the next result waits for that register to empty.
// Configuration registers are written through a plain write port and should
// only be changed while the block is idle.
module battery_low_monitor
  import blm_pkg::*;
#(
  parameter int SAMPLES_PER_READING = 8,
  parameter int ADC_BITS            = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  blm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output blm_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Commands and status between the sequencer and the arithmetic.
  blm_cmd_t  cmd;
  blm_stat_t stat;

  // The controller walks each completed group through mean, multiply,
  // fold, average and output steps, and accepts input only when idle.
  blm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .usb_present (in_data.usb_present),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // The datapath holds the configuration, the group sum, the folding
  // divider, the running average, the low-reading run and the output
  // register.
  blm_datapath #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .ADC_BITS            (ADC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .adc_sample (in_data.adc_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* src/blm_ctrl.sv */
module blm_ctrl
  import blm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      usb_present,
  output logic      in_ready,
  input  blm_stat_t stat,
  output blm_cmd_t  cmd
);

  blm_state_t state;
  blm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (usb_present) begin
            cmd.clear_usb = 1'b1;
          end else begin
            cmd.add_sample = 1'b1;
            if (stat.last_sample) begin
              state_next = ST_MEAN;
            end
          end
        end
      end
      ST_MEAN: begin
        cmd.mean_load = 1'b1;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_first = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.fold_load = 1'b1;
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (stat.fold_done) begin
          state_next = ST_AVG;
        end else begin
          cmd.fold_step = 1'b1;
        end
      end
      ST_AVG: begin
        cmd.avg_update = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/blm_datapath.sv */
module blm_datapath
  import blm_pkg::*;
#(
  parameter int SAMPLES_PER_READING = 8,
  parameter int ADC_BITS            = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  blm_cmd_t              cmd,
  output blm_stat_t             stat,
  input  logic [SAMPLE_W-1:0]   adc_sample,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output blm_out_t              out_data
);

  localparam int LOG2_S   = $clog2(SAMPLES_PER_READING);
  localparam int SUM_W    = ADC_BITS + LOG2_S;
  localparam int IDX_W    = (LOG2_S > 0) ? LOG2_S : 1;
  localparam int EXT_W    = (ADC_BITS > SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int PROD_W   = ADC_BITS + DIVIDER_W;
  localparam int NUM_W    = PROD_W + FULL_SCALE_W;
  localparam int HI_W     = NUM_W - ADC_BITS;
  localparam bit BY_SHIFT = (SAMPLES_PER_READING == (1 << LOG2_S));

  // Reciprocal of the group size, exact for every sum that fits SUM_W bits.
  localparam int     RECIP_SHIFT = SUM_W + LOG2_S;
  localparam int     RECIP_W     = SUM_W + 1;
  localparam int     MPROD_W     = SUM_W + RECIP_W;
  localparam longint RECIP_LONG  = ((longint'(1) << RECIP_SHIFT) + SAMPLES_PER_READING - 1)
                                   / SAMPLES_PER_READING;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(RECIP_LONG);

  localparam logic [NUM_W-1:0] ADC_MAX_N = NUM_W'((1 << ADC_BITS) - 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SAMPLES_PER_READING - 1);

  // Configuration registers.
  logic [MV_W-1:0]      cut_mv;
  logic [DIVIDER_W-1:0] divider_q4;
  logic [COUNT_W-1:0]   needed_lows;

  // Reading state.
  logic [SUM_W-1:0]   sample_sum;
  logic [IDX_W-1:0]   sample_index;
  logic [AVG_W-1:0]   average_q4;
  logic [COUNT_W-1:0] low_run;

  // Arithmetic registers.
  logic [ADC_BITS-1:0] mean;
  logic [PROD_W-1:0]   prod;
  logic [NUM_W-1:0]    fold_rem;
  logic [AVG_W-1:0]    fold_quot;

  logic [ADC_BITS-1:0] sample;
  logic [MPROD_W-1:0]  mean_prod;
  logic [ADC_BITS-1:0] mean_calc;
  logic [NUM_W-1:0]    num;
  logic [HI_W-1:0]     fold_hi;
  logic [ADC_BITS-1:0] fold_lo;
  logic [AVG_W-1:0]    scaled;
  logic [AVG_W:0]      avg_sum;
  logic [AVG_W:0]      mv_round;
  logic [MV_W-1:0]     mv;
  logic                is_low;
  logic [COUNT_W-1:0]  low_run_next;

  assign sample = ADC_BITS'(EXT_W'(adc_sample));

  assign mean_prod = MPROD_W'(sample_sum) * MPROD_W'(RECIP_MUL);

  always_comb begin
    if (BY_SHIFT) begin
      mean_calc = ADC_BITS'(sample_sum >> LOG2_S);
    end else begin
      mean_calc = ADC_BITS'(mean_prod >> RECIP_SHIFT);
    end
  end

  // Division by 2^ADC_BITS - 1: each step moves the high part of the
  // remainder into the quotient and adds it back onto the low part.
  assign num     = NUM_W'(prod) * NUM_W'(FULL_SCALE_MV);
  assign fold_hi = fold_rem[NUM_W-1:ADC_BITS];
  assign fold_lo = fold_rem[ADC_BITS-1:0];
  assign scaled  = fold_quot + AVG_W'(fold_rem == ADC_MAX_N);

  assign avg_sum  = {1'b0, average_q4} + {1'b0, scaled};
  assign mv_round = ({1'b0, average_q4} + (AVG_W + 1)'(1 << (FRAC_W - 1))) >> FRAC_W;
  assign mv       = (mv_round > (AVG_W + 1)'({MV_W{1'b1}})) ? {MV_W{1'b1}}
                                                           : mv_round[MV_W-1:0];
  assign is_low   = (mv < cut_mv);

  always_comb begin
    if (!is_low) begin
      low_run_next = '0;
    end else if (low_run == LOW_RUN_MAX) begin
      low_run_next = LOW_RUN_MAX;
    end else begin
      low_run_next = low_run + 1'b1;
    end
  end

  assign stat.last_sample = (sample_index == LAST_IDX);
  assign stat.fold_done   = (fold_hi == '0);
  assign stat.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_mv      <= CUT_MV_RESET;
      divider_q4  <= DIVIDER_Q4_RESET;
      needed_lows <= NEEDED_LOWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUT_MV:      cut_mv      <= cfg_data[MV_W-1:0];
        CFG_DIVIDER_Q4:  divider_q4  <= cfg_data[DIVIDER_W-1:0];
        CFG_NEEDED_LOWS: needed_lows <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_index <= '0;
      average_q4   <= '0;
      low_run      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.clear_usb) begin
        sample_sum   <= '0;
        sample_index <= '0;
        low_run      <= '0;
      end
      if (cmd.add_sample) begin
        sample_sum   <= sample_sum + SUM_W'(sample);
        sample_index <= stat.last_sample ? '0 : sample_index + 1'b1;
      end
      if (cmd.mean_load) begin
        sample_sum <= '0;
      end
      if (cmd.avg_update) begin
        if (average_q4 < AVG_W'(1 << FRAC_W)) begin
          average_q4 <= scaled;
        end else begin
          average_q4 <= avg_sum[AVG_W:1];
        end
      end
      if (cmd.emit) begin
        low_run   <= low_run_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_load) begin
      mean <= mean_calc;
    end
    if (cmd.mul_first) begin
      prod <= PROD_W'(mean) * PROD_W'(divider_q4);
    end
    if (cmd.fold_load) begin
      fold_rem  <= num;
      fold_quot <= '0;
    end else if (cmd.fold_step) begin
      fold_quot <= fold_quot + AVG_W'(fold_hi);
      fold_rem  <= NUM_W'(fold_lo) + NUM_W'(fold_hi);
    end
    if (cmd.emit) begin
      out_data.battery_mv    <= mv;
      out_data.is_low        <= is_low;
      out_data.low_count     <= low_run_next;
      out_data.sleep_request <= is_low && (low_run_next >= needed_lows);
    end
  end

  // Once the fold has finished, the remainder is at most the full-scale code.
  assert property (@(posedge clk) disable iff (rst)
    cmd.avg_update |-> (fold_rem <= ADC_MAX_N))
    else $error("fold remainder out of range");

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken result");

  // A low reading always has a non-zero run, a healthy one a cleared run.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_low == (out_data.low_count != '0)))
    else $error("low run disagrees with low flag");

  // Sleep is only requested on a low reading.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.sleep_request) |-> out_data.is_low)
    else $error("sleep requested on a healthy reading");

endmodule

/* sim/battery_low_monitor_test.sv */
// Self-checking bench for the low-battery monitor. A clocked driver offers
// ADC samples and external-power notices from a queue that the stimulus
// process fills. Each transfer that the block accepts is run through a model
// of the sample grouping, scaling, running average and low-reading counter,
// and the reading that it completes, if any, is queued. A clocked monitor
// takes each result transfer and compares it field by field with the oldest
// queued reading. The configuration registers change only between phases,
// once the block has drained and settled.
module battery_low_monitor_test;
  import blm_pkg::*;

  localparam int     GROUP_SIZE      = 8;
  localparam longint ADC_FULL_CODE   = (1 << SAMPLE_W) - 1;
  localparam longint AVG_LIMIT       = (1 << AVG_W) - 1;
  localparam int     SETTLE_CYCLES   = 40;
  localparam int     WATCHDOG_LIMIT  = 2000;
  localparam int     LONG_HOLD       = 400;
  localparam int     PHASES          = 10;
  localparam int     ITEMS_PER_PHASE = 143;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  blm_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  blm_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  battery_low_monitor u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Samples waiting to be offered, and readings waiting to come out.
  blm_in_t  pending_samples[$];
  blm_out_t expected_readings[$];

  int items_queued   = 0;
  int items_accepted = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // Set by the stimulus process: no idling on either side from here on, and
  // a request for one long stall of the result channel.
  bit calm         = 1'b0;
  bit hold_request = 1'b0;

  // Our copy of the register settings, mirrored whenever one is written.
  logic [MV_W-1:0]      cut_setting     = CUT_MV_RESET;
  logic [DIVIDER_W-1:0] divider_setting = DIVIDER_Q4_RESET;
  logic [COUNT_W-1:0]   needed_setting  = NEEDED_LOWS_RESET;

  // Our copy of the block's state.
  logic [12:0]          group_sum  = '0;
  int                   group_fill = 0;
  logic [AVG_W-1:0]     average_q4 = '0;
  logic [COUNT_W-1:0]   low_run    = '0;

  // Follows one accepted transfer through the monitor's arithmetic. An
  // external-power notice clears the partial group and the low run but keeps
  // the average. The eighth sample of a group completes a reading: the floored
  // mean is scaled to millivolts with four fraction bits, then seeds the
  // average if that is still below 1 mV, or else is averaged into it.
  task automatic track_sample(input blm_in_t item);
    longint             scaled;
    logic [AVG_W:0]     avg_sum;
    logic [AVG_W:0]     rounded;
    blm_out_t           reading;
    if (item.usb_present) begin
      group_sum  = '0;
      group_fill = 0;
      low_run    = '0;
    end else begin
      group_sum  = group_sum + item.adc_sample;
      group_fill = group_fill + 1;
      if (group_fill == GROUP_SIZE) begin
        scaled = longint'(group_sum) / GROUP_SIZE * longint'(FULL_SCALE_MV)
                 * longint'(divider_setting) / ADC_FULL_CODE;
        if (scaled > AVG_LIMIT) scaled = AVG_LIMIT;
        group_sum  = '0;
        group_fill = 0;
        if (average_q4 < 16) begin
          average_q4 = scaled[AVG_W-1:0];
        end else begin
          avg_sum    = {1'b0, average_q4} + {1'b0, scaled[AVG_W-1:0]};
          average_q4 = avg_sum[AVG_W:1];
        end
        // Round to whole millivolts and saturate at the field's top.
        rounded = ({1'b0, average_q4} + (AVG_W + 1)'(8)) >> FRAC_W;
        if (rounded > 65535) rounded = (AVG_W + 1)'(65535);
        reading.battery_mv = rounded[MV_W-1:0];
        reading.is_low     = (rounded[MV_W-1:0] < cut_setting);
        // A healthy reading ends the run; a low one extends it up to 15.
        if (reading.is_low) begin
          if (low_run != LOW_RUN_MAX) low_run = low_run + 1'b1;
        end else begin
          low_run = '0;
        end
        reading.low_count     = low_run;
        reading.sleep_request = reading.is_low && (low_run >= needed_setting);
        expected_readings.push_back(reading);
      end
    end
  endtask

  // Input driver. A transfer takes place at an edge where valid and ready are
  // both high; only then, or while valid is low, may the next item or a gap
  // be chosen, so an offered item never changes or disappears.
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        track_sample(in_data);
        items_accepted = items_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_data  <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver. Short stalls come in random bursts; once asked, it also
  // holds off for one long stretch so that the output register stays full,
  // the next reading backs up behind it and the input has to stall.
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count = mismatch_count + 1;
    end
  endtask

  // Result monitor: every result transfer must match the oldest reading.
  blm_out_t wanted;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: result with no reading expected, got mv %0d low %0b count %0d sleep %0b",
                 $time, out_data.battery_mv, out_data.is_low, out_data.low_count,
                 out_data.sleep_request);
        mismatch_count = mismatch_count + 1;
      end else begin
        wanted = expected_readings.pop_front();
        check_field("battery_mv", wanted.battery_mv, out_data.battery_mv);
        check_field("is_low", wanted.is_low, out_data.is_low);
        check_field("low_count", wanted.low_count, out_data.low_count);
        check_field("sleep_request", wanted.sleep_request, out_data.sleep_request);
      end
    end
  end

  // Watchdog: too long without a transfer on either channel means the block
  // has hung or lost a result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic add_item(input logic usb, input int sample);
    blm_in_t item;
    item.usb_present = usb;
    item.adc_sample  = sample[SAMPLE_W-1:0];
    pending_samples.push_back(item);
    items_queued = items_queued + 1;
  endtask

  // Mostly complete groups of eight samples scattered around a level that
  // drifts slowly, so that runs of low and healthy readings both build up.
  // Some groups are cut short by external power, and some notices come alone.
  task automatic queue_readings(input int count, input bit with_power);
    int level;
    int spread;
    int done;
    int roll;
    int sample;
    int n;
    level = $urandom_range(0, 1023);
    done  = 0;
    while (done < count) begin
      roll = with_power ? $urandom_range(0, 99) : 99;
      if (roll < 4) begin
        add_item(1'b1, $urandom_range(0, 1023));
        done = done + 1;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          level = $urandom_range(0, 1023);
        end else begin
          level = level + $urandom_range(0, 80) - 40;
          if (level < 0) level = 0;
          if (level > 1023) level = 1023;
        end
        spread = $urandom_range(0, 40);
        n = (roll < 10) ? $urandom_range(1, 7) : GROUP_SIZE;
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 39) == 0) begin
            sample = $urandom_range(0, 1) ? 1023 : 0;
          end else begin
            sample = level + $urandom_range(0, 2 * spread) - spread;
            if (sample < 0) sample = 0;
            if (sample > 1023) sample = 1023;
          end
          add_item(1'b0, sample);
        end
        done = done + n;
        if (n != GROUP_SIZE) begin
          add_item(1'b1, $urandom_range(0, 1023));
          done = done + 1;
        end
      end
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_CUT_MV:      cut_setting     = value[MV_W-1:0];
      CFG_DIVIDER_Q4:  divider_setting = value[DIVIDER_W-1:0];
      CFG_NEEDED_LOWS: needed_setting  = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Waits for every queued sample to be taken and every reading to come out,
  // then lets the block finish any work that produces no result.
  task automatic wait_until_drained();
    while (items_accepted != items_queued || expected_readings.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int cut;
    int divider;
    int needed;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opening with the reset settings. A full-scale group seeds the
    // average well above the cut; a partial group is then thrown away by
    // external power (whose sample field is ignored); a group of zeros halves
    // the average to a low reading; a lone notice ends the low run.
    for (int k = 0; k < GROUP_SIZE; k++) add_item(1'b0, 1023);
    add_item(1'b1, 0);
    for (int k = 0; k < 3; k++) add_item(1'b0, 512);
    add_item(1'b1, 1023);
    for (int k = 0; k < GROUP_SIZE; k++) add_item(1'b0, 0);
    add_item(1'b1, 341);
    wait_until_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          // Everything is low: the run saturates and sleep needs fifteen.
          cut = 65535; divider = 255; needed = 15;
        end
        1: begin
          // Zero divider scales every reading to nothing and no cut is hit.
          cut = 0; divider = 0; needed = 0;
        end
        2: begin
          cut = CUT_MV_RESET; divider = DIVIDER_Q4_RESET; needed = 1;
        end
        3: begin
          // Unity divider ratio (16 in Q4); with no lows needed, every low
          // reading asks for sleep.
          divider = 16; cut = $urandom_range(0, 3100); needed = 0;
        end
        default: begin
          divider = $urandom_range(0, 255);
          cut     = $urandom_range(0, 3000 * divider / 16 + 64);
          needed  = $urandom_range(0, 15);
        end
      endcase
      write_register(CFG_CUT_MV, cut);
      write_register(CFG_DIVIDER_Q4, divider);
      write_register(CFG_NEEDED_LOWS, needed);
      if (phase == 4) hold_request = 1'b1;
      if (phase == PHASES - 1) calm = 1'b1;
      queue_readings(ITEMS_PER_PHASE, phase != 0);
      wait_until_drained();
    end

    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
